/* sv/sbb_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and the reciprocal table of the sliding box blur line core.
package sbb_pkg;

    // Line and window limits.
    localparam int MAX_RADIUS = 24;
    localparam int MAX_LINE   = 4096;
    localparam int POS_W      = $clog2(MAX_LINE);
    localparam int RADIUS_W   = 5;

    // Pixel layout: four 8-bit channels, alpha in the lowest byte.
    localparam int CHAN_W     = 8;
    localparam int NUM_CHAN   = 4;
    localparam int PIXEL_W    = NUM_CHAN * CHAN_W;

    // Pixel ring and running sums.
    localparam int RING_DEPTH = 64;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int SUM_W      = 14;

    // Window count and reciprocal divide.
    localparam int CNT_W       = 6;
    localparam int RECIP_DEPTH = 2 ** CNT_W;
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int RECIP_ONE   = 2 ** RECIP_SHIFT;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // Item queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QCOUNT_W    = QUEUE_AW + 1;

    localparam logic [RADIUS_W-1:0] RADIUS_LIMIT = RADIUS_W'(MAX_RADIUS);
    localparam logic [POS_W-1:0]    LAST_POS     = POS_W'(MAX_LINE - 1);

    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] pixel_t;

    // One classified input item as the back end consumes it.
    typedef struct packed {
        pixel_t                pixel;
        logic [POS_W-1:0]      pos;
        logic [RADIUS_W-1:0]   radius;
        logic [POS_W-1:0]      x_first;
        logic                  emit_first;
        logic                  last;
    } sbb_item_t;

    // Back-end sequencer states.
    typedef enum logic {
        SEQ_TAKE,
        SEQ_FLUSH
    } seq_state_t;

    // Entry d holds ceil(2^RECIP_SHIFT / d); exact floor division for any 14-bit sum.
    localparam logic [RECIP_W-1:0] RECIP_TABLE [RECIP_DEPTH] = '{
        1:  RECIP_W'(RECIP_ONE),
        2:  RECIP_W'((RECIP_ONE + 1) / 2),   3:  RECIP_W'((RECIP_ONE + 2) / 3),
        4:  RECIP_W'((RECIP_ONE + 3) / 4),   5:  RECIP_W'((RECIP_ONE + 4) / 5),
        6:  RECIP_W'((RECIP_ONE + 5) / 6),   7:  RECIP_W'((RECIP_ONE + 6) / 7),
        8:  RECIP_W'((RECIP_ONE + 7) / 8),   9:  RECIP_W'((RECIP_ONE + 8) / 9),
        10: RECIP_W'((RECIP_ONE + 9) / 10),  11: RECIP_W'((RECIP_ONE + 10) / 11),
        12: RECIP_W'((RECIP_ONE + 11) / 12), 13: RECIP_W'((RECIP_ONE + 12) / 13),
        14: RECIP_W'((RECIP_ONE + 13) / 14), 15: RECIP_W'((RECIP_ONE + 14) / 15),
        16: RECIP_W'((RECIP_ONE + 15) / 16), 17: RECIP_W'((RECIP_ONE + 16) / 17),
        18: RECIP_W'((RECIP_ONE + 17) / 18), 19: RECIP_W'((RECIP_ONE + 18) / 19),
        20: RECIP_W'((RECIP_ONE + 19) / 20), 21: RECIP_W'((RECIP_ONE + 20) / 21),
        22: RECIP_W'((RECIP_ONE + 21) / 22), 23: RECIP_W'((RECIP_ONE + 22) / 23),
        24: RECIP_W'((RECIP_ONE + 23) / 24), 25: RECIP_W'((RECIP_ONE + 24) / 25),
        26: RECIP_W'((RECIP_ONE + 25) / 26), 27: RECIP_W'((RECIP_ONE + 26) / 27),
        28: RECIP_W'((RECIP_ONE + 27) / 28), 29: RECIP_W'((RECIP_ONE + 28) / 29),
        30: RECIP_W'((RECIP_ONE + 29) / 30), 31: RECIP_W'((RECIP_ONE + 30) / 31),
        32: RECIP_W'((RECIP_ONE + 31) / 32), 33: RECIP_W'((RECIP_ONE + 32) / 33),
        34: RECIP_W'((RECIP_ONE + 33) / 34), 35: RECIP_W'((RECIP_ONE + 34) / 35),
        36: RECIP_W'((RECIP_ONE + 35) / 36), 37: RECIP_W'((RECIP_ONE + 36) / 37),
        38: RECIP_W'((RECIP_ONE + 37) / 38), 39: RECIP_W'((RECIP_ONE + 38) / 39),
        40: RECIP_W'((RECIP_ONE + 39) / 40), 41: RECIP_W'((RECIP_ONE + 40) / 41),
        42: RECIP_W'((RECIP_ONE + 41) / 42), 43: RECIP_W'((RECIP_ONE + 42) / 43),
        44: RECIP_W'((RECIP_ONE + 43) / 44), 45: RECIP_W'((RECIP_ONE + 44) / 45),
        46: RECIP_W'((RECIP_ONE + 45) / 46), 47: RECIP_W'((RECIP_ONE + 46) / 47),
        48: RECIP_W'((RECIP_ONE + 47) / 48), 49: RECIP_W'((RECIP_ONE + 48) / 49),
        50: RECIP_W'((RECIP_ONE + 49) / 50), 51: RECIP_W'((RECIP_ONE + 50) / 51),
        52: RECIP_W'((RECIP_ONE + 51) / 52), 53: RECIP_W'((RECIP_ONE + 52) / 53),
        54: RECIP_W'((RECIP_ONE + 53) / 54), 55: RECIP_W'((RECIP_ONE + 54) / 55),
        56: RECIP_W'((RECIP_ONE + 55) / 56), 57: RECIP_W'((RECIP_ONE + 56) / 57),
        58: RECIP_W'((RECIP_ONE + 57) / 58), 59: RECIP_W'((RECIP_ONE + 58) / 59),
        60: RECIP_W'((RECIP_ONE + 59) / 60), 61: RECIP_W'((RECIP_ONE + 60) / 61),
        62: RECIP_W'((RECIP_ONE + 61) / 62), 63: RECIP_W'((RECIP_ONE + 62) / 63),
        default: RECIP_W'(0)
    };

endpackage

/* sv/sbb_front.sv */
`timescale 1ns / 1ps
// Front end: accepts pixels, tracks the line position and radius, classifies each item.
module sbb_front
    import sbb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  pixel_t              s_axis_tdata,
    input  logic                s_axis_tlast,
    input  logic                cfg_wr_en,
    input  logic [RADIUS_W-1:0] cfg_wr_data,
    input  logic                queue_full,
    output logic                push,
    output sbb_item_t           push_item
);

    logic [RADIUS_W-1:0] radius_reg, radius_next;
    logic [RADIUS_W-1:0] line_radius_reg, line_radius_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [RADIUS_W-1:0] radius_sat;
    logic [RADIUS_W-1:0] r_cur;
    logic [POS_W-1:0]    r_wide;
    logic                last;
    logic                p_ge_r;

    // The radius is saturated at the window limit and latched on a line's first pixel.
    assign radius_sat = (radius_reg > RADIUS_LIMIT) ? RADIUS_LIMIT : radius_reg;
    assign r_cur      = (pos_reg == '0) ? radius_sat : line_radius_reg;
    assign r_wide     = POS_W'(r_cur);

    // A full-length line ends at the last position even without tlast.
    assign last   = s_axis_tlast || (pos_reg == LAST_POS);
    assign p_ge_r = (pos_reg >= r_wide);

    // Handshake into the queue.
    assign s_axis_tready = !queue_full;
    assign push          = s_axis_tvalid && !queue_full;

    // Classify: the first output owed by this item and whether it owes one at all.
    always_comb
    begin
        push_item.pixel      = s_axis_tdata;
        push_item.pos        = pos_reg;
        push_item.radius     = r_cur;
        push_item.x_first    = p_ge_r ? (pos_reg - r_wide) : '0;
        push_item.emit_first = p_ge_r || last;
        push_item.last       = last;
    end

    // Next state of the position, radius and configuration registers.
    always_comb
    begin
        radius_next      = cfg_wr_en ? cfg_wr_data : radius_reg;
        pos_next         = pos_reg;
        line_radius_next = line_radius_reg;
        if (push)
        begin
            pos_next         = last ? '0 : (pos_reg + POS_W'(1));
            line_radius_next = r_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg      <= '0;
            line_radius_reg <= '0;
            pos_reg         <= '0;
        end
        else
        begin
            radius_reg      <= radius_next;
            line_radius_reg <= line_radius_next;
            pos_reg         <= pos_next;
        end
    end

endmodule

/* sv/sbb_queue.sv */
`timescale 1ns / 1ps
// Short item queue that decouples the front end from the back end.
module sbb_queue
    import sbb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  sbb_item_t push_item,
    output logic      full,
    input  logic      pop,
    output sbb_item_t head,
    output logic      head_valid
);

    sbb_item_t             slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCOUNT_W-1:0]   count_reg, count_next;

    assign full       = (count_reg == QCOUNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    // Pointers wrap on their own since the depth is a power of two.
    always_comb
    begin
        wr_ptr_next = push ? (wr_ptr_reg + QUEUE_AW'(1)) : wr_ptr_reg;
        rd_ptr_next = pop ? (rd_ptr_reg + QUEUE_AW'(1)) : rd_ptr_reg;
        count_next  = count_reg + QCOUNT_W'(push) - QCOUNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Item storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

/* sv/sbb_back.sv */
`timescale 1ns / 1ps
// Back end: output sequencer, pixel ring, running sums and reciprocal divide.
module sbb_back
    import sbb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sbb_item_t head,
    input  logic      head_valid,
    output logic      pop,
    output logic      flushing,
    output logic      m_axis_tvalid,
    input  logic      m_axis_tready,
    output pixel_t    m_axis_tdata,
    output logic      m_axis_tlast
);

    // Sequencer.
    seq_state_t          state_reg, state_next;
    logic [POS_W-1:0]    x_reg, x_next;
    logic [POS_W-1:0]    p_reg, p_next;
    logic [RADIUS_W-1:0] r_reg, r_next;
    logic                adv;

    // Operation issued this cycle.
    logic [POS_W-1:0]    op_x, op_p, op_diff, op_lo, op_cnt_wide;
    logic [RADIUS_W-1:0] op_r;
    logic                op_valid, op_first, op_emit, op_last, op_sub;
    logic [RING_AW-1:0]  op_addr;

    // Ring memory.
    pixel_t              ring_mem [RING_DEPTH];
    pixel_t              ring_rd_reg;

    // Sum stage.
    logic                b_valid_reg, b_valid_next;
    logic                b_first_reg, b_emit_reg, b_sub_reg, b_bypass_reg, b_last_reg;
    logic [CNT_W-1:0]    b_cnt_reg;
    pixel_t              b_pixel_reg;
    pixel_t              sub_pix;
    logic [SUM_W-1:0]    sum_reg [NUM_CHAN];
    logic [SUM_W-1:0]    sum_next [NUM_CHAN];
    logic [SUM_W-1:0]    sum_in [NUM_CHAN];

    // Multiply stage.
    logic                c_valid_reg, c_valid_next;
    logic [SUM_W-1:0]    c_sum_reg [NUM_CHAN];
    logic [RECIP_W-1:0]  c_recip_reg;
    logic                c_last_reg;
    logic [PROD_W-1:0]   prod [NUM_CHAN];

    // Output register.
    logic                out_valid_reg, out_valid_next;
    pixel_t              out_pixel_reg;
    logic                out_last_reg;

    // The whole back pipeline moves when the output register is free or being drained.
    assign adv      = !out_valid_reg || m_axis_tready;
    assign flushing = (state_reg == SEQ_FLUSH);

    // Sequencer: one op per unstalled cycle, the item's own first, then a line-end flush.
    always_comb
    begin
        state_next = state_reg;
        x_next     = x_reg;
        p_next     = p_reg;
        r_next     = r_reg;
        pop        = 1'b0;
        op_valid   = 1'b0;
        op_first   = 1'b0;
        op_emit    = 1'b0;
        op_last    = 1'b0;
        op_x       = x_reg;
        op_p       = p_reg;
        op_r       = r_reg;
        unique case (state_reg)
            SEQ_TAKE:
            begin
                op_x = head.x_first;
                op_p = head.pos;
                op_r = head.radius;
                if (head_valid && adv)
                begin
                    pop      = 1'b1;
                    op_valid = 1'b1;
                    op_first = 1'b1;
                    op_emit  = head.emit_first;
                    op_last  = head.last && (head.x_first == head.pos);
                    if (head.last && (head.x_first != head.pos))
                    begin
                        state_next = SEQ_FLUSH;
                        x_next     = head.x_first + POS_W'(1);
                        p_next     = head.pos;
                        r_next     = head.radius;
                    end
                end
            end
            SEQ_FLUSH:
            begin
                if (adv)
                begin
                    op_valid = 1'b1;
                    op_emit  = 1'b1;
                    op_last  = (x_reg == p_reg);
                    if (x_reg == p_reg)
                    begin
                        state_next = SEQ_TAKE;
                    end
                    else
                    begin
                        x_next = x_reg + POS_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = SEQ_TAKE;
            end
        endcase
    end

    // Window of output x: left edge max(x-r, 0), right edge the newest pixel.
    always_comb
    begin
        op_diff     = op_x - POS_W'(op_r);
        op_sub      = op_emit && (op_x >= POS_W'(op_r));
        op_lo       = (op_x >= POS_W'(op_r)) ? op_diff : '0;
        op_cnt_wide = op_p - op_lo + POS_W'(1);
        op_addr     = op_diff[RING_AW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_TAKE;
            x_reg     <= '0;
            p_reg     <= '0;
            r_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            x_reg     <= x_next;
            p_reg     <= p_next;
            r_reg     <= r_next;
        end
    end

    // Pixel ring: the new pixel is written as its item is taken, the leaving pixel is read.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ring_mem[head.pos[RING_AW-1:0]] <= head.pixel;
        end
        if (adv)
        begin
            ring_rd_reg <= ring_mem[op_addr];
        end
    end

    // Sum stage registers.
    assign b_valid_next = adv ? op_valid : b_valid_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_first_reg  <= op_first;
            b_emit_reg   <= op_emit;
            b_sub_reg    <= op_sub;
            b_bypass_reg <= (op_r == '0);
            b_last_reg   <= op_last;
            b_cnt_reg    <= op_cnt_wide[CNT_W-1:0];
            b_pixel_reg  <= head.pixel;
        end
    end

    // With radius zero the leaving pixel is the one entering in the same cycle.
    assign sub_pix = b_bypass_reg ? b_pixel_reg : ring_rd_reg;

    // Running sums: add the entering pixel, show, drop the leaving one; zero at a line end.
    always_comb
    begin
        for (int ch = 0; ch < NUM_CHAN; ch++)
        begin
            sum_in[ch] = sum_reg[ch] + (b_first_reg ? SUM_W'(b_pixel_reg[ch]) : '0);
            sum_next[ch] = sum_reg[ch];
            if (adv && b_valid_reg)
            begin
                sum_next[ch] = b_last_reg ? '0 :
                    (sum_in[ch] - (b_sub_reg ? SUM_W'(sub_pix[ch]) : '0));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int ch = 0; ch < NUM_CHAN; ch++)
            begin
                sum_reg[ch] <= '0;
            end
        end
        else
        begin
            for (int ch = 0; ch < NUM_CHAN; ch++)
            begin
                sum_reg[ch] <= sum_next[ch];
            end
        end
    end

    // Multiply stage registers: sum and reciprocal of the window count.
    assign c_valid_next = adv ? (b_valid_reg && b_emit_reg) : c_valid_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int ch = 0; ch < NUM_CHAN; ch++)
            begin
                c_sum_reg[ch] <= sum_in[ch];
            end
            c_recip_reg <= RECIP_TABLE[b_cnt_reg];
            c_last_reg  <= b_last_reg;
        end
    end

    // Truncating divide by reciprocal multiply.
    always_comb
    begin
        for (int ch = 0; ch < NUM_CHAN; ch++)
        begin
            prod[ch] = PROD_W'(c_sum_reg[ch]) * PROD_W'(c_recip_reg);
        end
    end

    // Output register.
    assign out_valid_next = adv ? c_valid_reg : out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int ch = 0; ch < NUM_CHAN; ch++)
            begin
                out_pixel_reg[ch] <= prod[ch][RECIP_SHIFT +: CHAN_W];
            end
            out_last_reg <= c_last_reg;
        end
    end

    // Pipeline valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg   <= b_valid_next;
            c_valid_reg   <= c_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_pixel_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

/* sv/sliding_box_blur_line_core.sv */
// Output x follows the acceptance of input x+radius, or of the line's last pixel.
// Throughput: one pixel per cycle while the queue has room; a line's last pixel holds
// the output sequencer while it issues the last min(radius, line length - 1) outputs.
// Reset (rst_n, asynchronous, active low) clears the radius, line position, sums,
// queue and pipeline flags; the pixel ring is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
module sliding_box_blur_line_core
    import sbb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [PIXEL_W-1:0]  s_axis_tdata,   // in_alpha, in_red, in_green, in_blue
    input  logic                s_axis_tlast,   // in_last
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [PIXEL_W-1:0]  m_axis_tdata,   // out_alpha, out_red, out_green, out_blue
    output logic                m_axis_tlast,   // out_last
    input  logic                cfg_wr_en,
    input  logic [RADIUS_W-1:0] cfg_wr_data     // blur_radius
);

    logic      push;
    logic      queue_full;
    sbb_item_t push_item;
    sbb_item_t head;
    logic      head_valid;
    logic      pop;
    logic      flushing;

    // Accept and classify.
    sbb_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .queue_full    (queue_full),
        .push          (push),
        .push_item     (push_item)
    );

    // Decoupling queue.
    sbb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    // Sequencing, sums and divide.
    sbb_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .head_valid    (head_valid),
        .pop           (pop),
        .flushing      (flushing),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

`ifndef NO_ASSERTIONS
    // The back end only takes items that are in the queue.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
        else $error("item taken from an empty queue");

    // No new item is taken while a line end is being flushed.
    assert property (@(posedge clk) disable iff (!rst_n) flushing |-> !pop)
        else $error("item taken during a line flush");

    // The front end never pushes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !queue_full)
        else $error("item pushed into a full queue");

    // A flush starts only from the item that ends a line.
    assert property (@(posedge clk) disable iff (!rst_n) $rose(flushing) |-> $past(pop && head.last))
        else $error("flush started without a line end");
`endif

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the sliding box blur line core: directed table and random lines.
module tb_top;
    import sbb_pkg::*;

    localparam int RAND_ITEMS   = 145;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 2_000_000;

    typedef enum logic {
        ROW_PIXEL,
        ROW_CONFIG
    } row_kind_t;

    // One output item as the block should deliver it.
    typedef struct packed {
        pixel_t px;
        logic   last;
    } blur_out_t;

    // One row of the directed table.
    typedef struct packed {
        row_kind_t           kind;
        logic [RADIUS_W-1:0] radius;
        pixel_t              px;
        logic                last;
        logic                typed;
        blur_out_t           want;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [PIXEL_W-1:0]  s_axis_tdata;   // in_alpha, in_red, in_green, in_blue
    logic                s_axis_tlast;   // in_last
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [PIXEL_W-1:0]  m_axis_tdata;   // out_alpha, out_red, out_green, out_blue
    logic                m_axis_tlast;   // out_last
    logic                cfg_wr_en;
    logic [RADIUS_W-1:0] cfg_wr_data;    // blur_radius

    sliding_box_blur_line_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    // Blur predictor state.
    pixel_t              line_ring [RING_DEPTH];
    logic [SUM_W-1:0]    chan_sum [NUM_CHAN];
    logic [POS_W-1:0]    next_pos;
    logic [RADIUS_W-1:0] line_radius;
    logic [RADIUS_W-1:0] radius_reg;

    blur_out_t  window_outs [$];
    blur_out_t  expected_px [$];
    stim_row_t  dir_rows [$];
    int         error_count;
    int         cycle_count;
    int         hold_request;
    string      chan_field [NUM_CHAN] = '{"out_alpha", "out_red", "out_green", "out_blue"};

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Emits output x of the window whose newest pixel is top; drops pixel x-r when x >= r.
    function automatic void emit_window(int x, int top, int r);
        int        lo;
        int        cnt;
        blur_out_t o;
        lo = (x >= r) ? x - r : 0;
        cnt = top - lo + 1;
        for (int ch = 0; ch < NUM_CHAN; ch++)
            o.px[ch] = CHAN_W'(int'(chan_sum[ch]) / cnt);
        o.last = 1'b0;
        window_outs.insert(window_outs.size(), o);
        if (x >= r)
        begin
            for (int ch = 0; ch < NUM_CHAN; ch++)
                chan_sum[ch] = chan_sum[ch] - SUM_W'(line_ring[(x - r) % RING_DEPTH][ch]);
        end
    endfunction

    // Advances the predictor by one accepted pixel; the outputs it causes go to window_outs.
    function automatic void blur_predict(pixel_t px, logic last_in);
        int   p;
        int   r;
        logic line_end;
        window_outs.delete();
        p = int'(next_pos);
        line_end = last_in || (p >= MAX_LINE - 1);
        if (p == 0)
            line_radius = (radius_reg > RADIUS_LIMIT) ? RADIUS_LIMIT : radius_reg;
        r = int'(line_radius);
        line_ring[p % RING_DEPTH] = px;
        for (int ch = 0; ch < NUM_CHAN; ch++)
            chan_sum[ch] = chan_sum[ch] + SUM_W'(px[ch]);
        if (p >= r)
            emit_window(p - r, p, r);
        if (line_end)
        begin
            for (int x = (p >= r) ? p - r + 1 : 0; x <= p; x++)
                emit_window(x, p, r);
            if (window_outs.size() > 0)
                window_outs[window_outs.size() - 1].last = 1'b1;
            for (int ch = 0; ch < NUM_CHAN; ch++)
                chan_sum[ch] = '0;
            next_pos = '0;
        end
        else
        begin
            next_pos = next_pos + POS_W'(1);
        end
    endfunction

    function automatic void book_predicted();
        foreach (window_outs[i])
            expected_px.insert(expected_px.size(), window_outs[i]);
    endfunction

    // Appends one row to the directed table.
    function automatic void add_row(stim_row_t row);
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return 0;
        if (sel < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic pixel_t rand_pixel();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return '0;
        if (sel == 1)
            return '1;
        return pixel_t'($urandom);
    endfunction

    function automatic stim_row_t pix_row(pixel_t px, logic last_in);
        stim_row_t row;
        row = '0;
        row.kind = ROW_PIXEL;
        row.px = px;
        row.last = last_in;
        return row;
    endfunction

    function automatic stim_row_t typed_row(pixel_t px, logic last_in, pixel_t want_px,
                                            logic want_last);
        stim_row_t row;
        row = pix_row(px, last_in);
        row.typed = 1'b1;
        row.want.px = want_px;
        row.want.last = want_last;
        return row;
    endfunction

    function automatic stim_row_t cfg_row(logic [RADIUS_W-1:0] radius);
        stim_row_t row;
        row = '0;
        row.kind = ROW_CONFIG;
        row.radius = radius;
        return row;
    endfunction

    // Offers one pixel after an optional gap and returns at the edge that accepts it.
    task automatic send_pixel(pixel_t px, logic last_in, int gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        s_axis_tlast  <= last_in;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send_and_book(pixel_t px, logic last_in, int gap);
        send_pixel(px, last_in, gap);
        blur_predict(px, last_in);
        book_predicted();
    endtask

    // Waits until every expected output has arrived and the pipeline has settled.
    task automatic wait_drained();
        while (expected_px.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_radius(logic [RADIUS_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        radius_reg = value;
    endtask

    // Compares one accepted output item with the oldest expectation.
    task automatic check_output();
        blur_out_t want;
        pixel_t    got;
        got = m_axis_tdata;
        if (expected_px.size() == 0)
        begin
            $error("unexpected output item: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
            error_count++;
            return;
        end
        want = expected_px.pop_front();
        for (int ch = 0; ch < NUM_CHAN; ch++)
        begin
            if (got[ch] !== want.px[ch])
            begin
                $error("%s mismatch: expected %0d, actual %0d", chan_field[ch],
                       want.px[ch], got[ch]);
                error_count++;
            end
        end
        if (m_axis_tlast !== want.last)
        begin
            $error("out_last mismatch: expected %0d, actual %0d", want.last, m_axis_tlast);
            error_count++;
        end
    endtask

    // Receiver: random back-pressure, quiet stretches and one long hold on request.
    initial
    begin
        int stall_left;
        int quiet_left;
        int hold_served;
        int sel;
        stall_left = 0;
        quiet_left = 0;
        hold_served = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                check_output();
            if (hold_served != hold_request)
            begin
                hold_served = hold_request;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if (quiet_left > 0)
                begin
                    quiet_left--;
                end
                else
                begin
                    sel = $urandom_range(0, 99);
                    if (sel < 4)
                        quiet_left = $urandom_range(50, 200);
                    else if (sel < 70)
                        stall_left = 0;
                    else if (sel < 95)
                        stall_left = $urandom_range(1, 3);
                    else
                        stall_left = $urandom_range(10, 40);
                end
            end
        end
    end

    // Run limit.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Sender: reset, directed table, then random lines.
    initial
    begin
        int        sent;
        int        nlines;
        int        len;
        int        sel;
        int        split_at;
        logic      hold_done;
        logic      no_gaps;
        stim_row_t row;

        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        error_count = 0;
        hold_request = 0;
        for (int ch = 0; ch < NUM_CHAN; ch++)
            chan_sum[ch] = '0;
        for (int i = 0; i < RING_DEPTH; i++)
            line_ring[i] = '0;
        next_pos = '0;
        line_radius = '0;
        radius_reg = '0;

        // Radius zero after reset: pixels pass through unchanged.
        add_row(typed_row(32'h00FF00FF, 1'b1, 32'h00FF00FF, 1'b1));
        add_row(typed_row(32'h00000000, 1'b0, 32'h00000000, 1'b0));
        add_row(typed_row(32'hFFFFFFFF, 1'b1, 32'hFFFFFFFF, 1'b1));
        add_row(typed_row(32'h5A3CC381, 1'b1, 32'h5A3CC381, 1'b1));
        // Smallest nonzero radius.
        add_row(cfg_row(5'd1));
        add_row(pix_row(32'h40302010, 1'b0));
        add_row(pix_row(32'h80706050, 1'b1));
        // Largest radius with a line shorter than the radius: everything at the last pixel.
        add_row(cfg_row(5'(MAX_RADIUS)));
        add_row(pix_row(32'hFFFFFFFF, 1'b0));
        add_row(pix_row(32'h00000000, 1'b0));
        add_row(pix_row(32'hFFFFFFFF, 1'b0));
        add_row(pix_row(32'h01010101, 1'b1));
        // Radius above the maximum saturates.
        add_row(cfg_row(5'd31));
        add_row(pix_row(32'hFFFFFFFF, 1'b0));
        add_row(pix_row(32'hFFFFFFFF, 1'b1));
        // A one-pixel line averages over itself alone.
        add_row(typed_row(32'h12345678, 1'b1, 32'h12345678, 1'b1));
        // A radius written inside a line applies from the next line on.
        add_row(cfg_row(5'd2));
        add_row(pix_row(32'hFF00FF00, 1'b0));
        add_row(pix_row(32'h00FF00FF, 1'b0));
        add_row(cfg_row(5'd0));
        add_row(pix_row(32'h80808080, 1'b0));
        add_row(pix_row(32'h7F7F7F7F, 1'b0));
        add_row(pix_row(32'hFFFFFFFF, 1'b1));
        add_row(typed_row(32'hA5F00F5A, 1'b1, 32'hA5F00F5A, 1'b1));
        // Alternating extremes exercise truncation of the averages.
        add_row(cfg_row(5'd3));
        for (int i = 0; i < 6; i++)
            add_row(pix_row((i % 2 == 0) ? 32'hFFFFFFFF : 32'h00000000, i == 5));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.kind == ROW_CONFIG)
            begin
                write_radius(row.radius);
            end
            else
            begin
                send_pixel(row.px, row.last, pick_gap());
                blur_predict(row.px, row.last);
                if (row.typed)
                    expected_px.insert(expected_px.size(), row.want);
                else
                    book_predicted();
            end
        end

        // Random lines under a sequence of radius settings.
        sent = 0;
        hold_done = 1'b0;
        while (sent < RAND_ITEMS)
        begin
            sel = $urandom_range(0, 9);
            if (sel < 2)
                write_radius('0);
            else if (sel < 3)
                write_radius(RADIUS_W'(MAX_RADIUS));
            else if (sel < 4)
                write_radius(RADIUS_W'($urandom_range(MAX_RADIUS + 1, 31)));
            else if (sel < 6)
                write_radius(RADIUS_W'($urandom_range(9, MAX_RADIUS - 1)));
            else
                write_radius(RADIUS_W'($urandom_range(1, 8)));
            nlines = $urandom_range(1, 4);
            for (int ln = 0; ln < nlines; ln++)
            begin
                if (sent >= RAND_ITEMS)
                    break;
                sel = $urandom_range(0, 99);
                if (sel < 55)
                    len = $urandom_range(1, 10);
                else if (sel < 85)
                    len = $urandom_range(11, 30);
                else
                    len = $urandom_range(31, 70);
                no_gaps = ($urandom_range(0, 4) == 0);
                split_at = ($urandom_range(0, 9) == 0 && len > 2) ? len / 2 : -1;
                // Once, hold the receiver off while the sender keeps the line coming.
                if (!hold_done && sent > 40)
                begin
                    hold_done = 1'b1;
                    len = 48;
                    no_gaps = 1'b1;
                    split_at = -1;
                    hold_request++;
                end
                // Keep the total close to the planned item count.
                if (len > RAND_ITEMS - sent)
                    len = RAND_ITEMS - sent;
                for (int i = 0; i < len; i++)
                begin
                    if (i == split_at)
                        write_radius(RADIUS_W'($urandom_range(0, 31)));
                    send_and_book(rand_pixel(), i == len - 1, no_gaps ? 0 : pick_gap());
                end
                sent += len;
            end
        end

        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* files.f */
sv/sbb_pkg.sv
sv/sbb_front.sv
sv/sbb_queue.sv
sv/sbb_back.sv
sv/sliding_box_blur_line_core.sv
dv/tb_top.sv
